// ===== design/mbe_pkg.sv =====
// Shared types and constants for the modular block encryptor.
package mbe_pkg;

   localparam int STAGE_COUNT = 4;
   localparam int WORD_WIDTH = 32;
   localparam int HALF_WIDTH = 16;
   localparam int DIV_BITS = 4;
   localparam int DIV_STEPS = WORD_WIDTH / DIV_BITS;
   localparam int ROUND_LATENCY = 2 + DIV_STEPS;
   localparam int BLOCK_LATENCY = STAGE_COUNT * ROUND_LATENCY + 1;

   localparam logic [7:0] CHECK_SEED = 8'hF8;
   localparam logic [7:0] TRAILER_MIX = 8'h3D;

   typedef enum logic [2:0] {
      REG_MODULUS_LO = 3'd0,
      REG_MODULUS_HI = 3'd1,
      REG_KEY_LO     = 3'd2,
      REG_KEY_HI     = 3'd3,
      REG_MASK_LO    = 3'd4,
      REG_MASK_HI    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [63:0] plain_block;
      logic [3:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [63:0] coded_head;
      logic [23:0] coded_tail;
   } rsp_type;

   // Block context carried down the pipeline next to each round.
   typedef struct packed {
      logic [63:0] plain_block;
      logic [3:0]  byte_count;
      logic [STAGE_COUNT-1:0][WORD_WIDTH-1:0] stage;
   } ctx_type;

endpackage

// ===== design/mbe_round.sv =====
// One cipher round: mask xor, 32-bit wrapping multiply, pipelined remainder.
module mbe_round
   import mbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ctx_type               in_ctx,
   input  logic [HALF_WIDTH-1:0] in_word,
   input  logic [WORD_WIDTH-1:0] mask,
   input  logic [WORD_WIDTH-1:0] key,
   input  logic [WORD_WIDTH-1:0] modulus,
   output logic                  out_valid,
   output ctx_type               out_ctx,
   output logic [WORD_WIDTH-1:0] out_result
);

   logic                  op_valid_ff;
   ctx_type               op_ctx_ff;
   logic [WORD_WIDTH-1:0] op_ff;

   logic                  valid_ff [DIV_STEPS+1];
   ctx_type               ctx_ff   [DIV_STEPS+1];
   logic [WORD_WIDTH-1:0] rem_ff   [DIV_STEPS+1];
   logic [WORD_WIDTH-1:0] dvd_ff   [DIV_STEPS+1];
   logic [WORD_WIDTH-1:0] rem_in   [DIV_STEPS];
   logic [WORD_WIDTH-1:0] dvd_in   [DIV_STEPS];

   logic [WORD_WIDTH-1:0] prod;

   // product wraps at 32 bits
   assign prod = op_ff * key;

   // Restoring remainder, DIV_BITS dividend bits per stage. A zero modulus
   // subtracts zero at every step, so the product falls through unreduced.
   always_comb begin
      logic [WORD_WIDTH:0]   t;
      logic [WORD_WIDTH-1:0] r;
      logic [WORD_WIDTH-1:0] d;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r = rem_ff[k];
         d = dvd_ff[k];
         for (int j = 0; j < DIV_BITS; j++) begin
            t = {r, d[WORD_WIDTH-1]};
            d = {d[WORD_WIDTH-2:0], 1'b0};
            if (t >= {1'b0, modulus}) begin
               t = t - {1'b0, modulus};
            end
            r = t[WORD_WIDTH-1:0];
         end
         rem_in[k] = r;
         dvd_in[k] = d;
      end
   end

   always_ff @(posedge clock) begin
      op_ctx_ff <= in_ctx;
      op_ff <= mask ^ {{(WORD_WIDTH-HALF_WIDTH){1'b0}}, in_word};
      ctx_ff[0] <= op_ctx_ff;
      rem_ff[0] <= '0;
      dvd_ff[0] <= prod;
      for (int k = 0; k < DIV_STEPS; k++) begin
         ctx_ff[k+1] <= ctx_ff[k];
         rem_ff[k+1] <= rem_in[k];
         dvd_ff[k+1] <= dvd_in[k];
      end
      if (reset) begin
         op_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         op_valid_ff <= in_valid;
         valid_ff[0] <= op_valid_ff;
         for (int k = 0; k < DIV_STEPS; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS];
   assign out_ctx = ctx_ff[DIV_STEPS];
   assign out_result = rem_ff[DIV_STEPS];

endmodule

// ===== design/modular_block_encryptor.sv =====
// Top level of the modular block encryptor: registers, round chain, packing.
//
// Takes one 8-byte block per clock whenever start is high; busy is never
// raised. Each block passes through four chained rounds (operand register,
// multiply register, 8 remainder stages at 4 bits each), then the output
// register. The result is held on rsp_data for one cycle under rsp_strobe
// and cannot be stalled.
module modular_block_encryptor
   import mbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] modulus_lo_ff, modulus_hi_ff;
   logic [63:0] key_lo_ff, key_hi_ff;
   logic [63:0] mask_lo_ff, mask_hi_ff;

   logic [WORD_WIDTH-1:0] mask_w [STAGE_COUNT];
   logic [WORD_WIDTH-1:0] key_w  [STAGE_COUNT];
   logic [WORD_WIDTH-1:0] mod_w  [STAGE_COUNT];

   logic                  rnd_in_valid [STAGE_COUNT];
   ctx_type               rnd_in_ctx   [STAGE_COUNT];
   logic [HALF_WIDTH-1:0] rnd_in_word  [STAGE_COUNT];
   logic                  rnd_out_valid [STAGE_COUNT];
   ctx_type               rnd_out_ctx   [STAGE_COUNT];
   logic [WORD_WIDTH-1:0] rnd_out_result [STAGE_COUNT];
   ctx_type               done_ctx [STAGE_COUNT];

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_lo_ff <= '0;
         modulus_hi_ff <= '0;
         key_lo_ff <= '0;
         key_hi_ff <= '0;
         mask_lo_ff <= '0;
         mask_hi_ff <= '0;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_MODULUS_LO: modulus_lo_ff <= csr_data;
            REG_MODULUS_HI: modulus_hi_ff <= csr_data;
            REG_KEY_LO:     key_lo_ff <= csr_data;
            REG_KEY_HI:     key_hi_ff <= csr_data;
            REG_MASK_LO:    mask_lo_ff <= csr_data;
            REG_MASK_HI:    mask_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mask_w[0] = mask_lo_ff[31:0];
      mask_w[1] = mask_lo_ff[63:32];
      mask_w[2] = mask_hi_ff[31:0];
      mask_w[3] = mask_hi_ff[63:32];
      key_w[0] = key_lo_ff[31:0];
      key_w[1] = key_lo_ff[63:32];
      key_w[2] = key_hi_ff[31:0];
      key_w[3] = key_hi_ff[63:32];
      mod_w[0] = modulus_lo_ff[31:0];
      mod_w[1] = modulus_lo_ff[63:32];
      mod_w[2] = modulus_hi_ff[31:0];
      mod_w[3] = modulus_hi_ff[63:32];
   end

   // Each round's word after the first is mixed with the low half of the round before it.
   always_comb begin
      for (int n = 0; n < STAGE_COUNT; n++) begin
         done_ctx[n] = rnd_out_ctx[n];
         done_ctx[n].stage[n] = rnd_out_result[n];
      end
      rnd_in_valid[0] = start && !busy;
      rnd_in_ctx[0].plain_block = req_data.plain_block;
      rnd_in_ctx[0].byte_count = req_data.byte_count;
      rnd_in_ctx[0].stage = '0;
      rnd_in_word[0] = req_data.plain_block[HALF_WIDTH-1:0];
      for (int n = 1; n < STAGE_COUNT; n++) begin
         rnd_in_valid[n] = rnd_out_valid[n-1];
         rnd_in_ctx[n] = done_ctx[n-1];
         rnd_in_word[n] = done_ctx[n-1].plain_block[n*HALF_WIDTH +: HALF_WIDTH]
                          ^ rnd_out_result[n-1][HALF_WIDTH-1:0];
      end
   end

   for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_round
      mbe_round u_round (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (rnd_in_valid[g]),
         .in_ctx     (rnd_in_ctx[g]),
         .in_word    (rnd_in_word[g]),
         .mask       (mask_w[g]),
         .key        (key_w[g]),
         .modulus    (mod_w[g]),
         .out_valid  (rnd_out_valid[g]),
         .out_ctx    (rnd_out_ctx[g]),
         .out_result (rnd_out_result[g])
      );
   end

   // Final mix, 18-bit packing per stage and the two trailer bytes.
   always_comb begin
      ctx_type               c;
      logic [WORD_WIDTH-1:0] s [STAGE_COUNT];
      logic [7:0]            cs;
      logic [87:0]           stream;
      c = done_ctx[STAGE_COUNT-1];
      for (int n = 0; n < STAGE_COUNT; n++) begin
         s[n] = c.stage[n];
      end
      for (int n = 0; n < STAGE_COUNT - 1; n++) begin
         s[n] = s[n] ^ mask_w[n]
                ^ {{(WORD_WIDTH-HALF_WIDTH){1'b0}}, c.stage[n+1][HALF_WIDTH-1:0]};
      end
      cs = CHECK_SEED;
      for (int b = 0; b < 8; b++) begin
         cs = cs ^ c.plain_block[8*b +: 8];
      end
      stream = {s[0][7:0], s[0][15:8], s[0][17], s[0][16],
                s[1][7:0], s[1][15:8], s[1][17], s[1][16],
                s[2][7:0], s[2][15:8], s[2][17], s[2][16],
                s[3][7:0], s[3][15:8], s[3][17], s[3][16],
                cs ^ {4'b0, c.byte_count} ^ TRAILER_MIX, cs};
      rsp_data_in.coded_head = stream[87:24];
      rsp_data_in.coded_tail = stream[23:0];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rnd_out_valid[STAGE_COUNT-1];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##41 rsp_strobe)
      else $error("accepted beat not delivered after pipeline latency");

   a_no_invented_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 41))
      else $error("result beat without matching accepted beat");

   a_round_chain: assert property (@(posedge clock) disable iff (reset)
      rnd_out_valid[0] |-> ##(3*ROUND_LATENCY) rnd_out_valid[STAGE_COUNT-1])
      else $error("round chain lost a beat");

endmodule
